// File: sv/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants of the separable box filter.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int MAX_WIDTH_DEF         = 1024;
  localparam int MAX_KERNEL_WIDTH_DEF  = 32;
  localparam int MAX_KERNEL_HEIGHT_DEF = 32;

  localparam int PIX_W       = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int IMG_W_W     = 11;
  localparam int IMG_H_W     = 16;
  localparam int KER_W       = 6;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST   = 11'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST  = 16'd480;
  localparam logic [KER_W-1:0]   KERNEL_WIDTH_RST  = 6'd3;
  localparam logic [KER_W-1:0]   KERNEL_HEIGHT_RST = 6'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_KERNEL_WIDTH  = 2'd2,
    CFG_KERNEL_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_READ,
    ST_LAST,
    ST_HDIV,
    ST_HWAIT,
    ST_VDIV,
    ST_VWAIT,
    ST_RESULT
  } state_t;

endpackage

// File: sv/sbf_if.sv
// ----------------------------------------------------------------------------
// sbf_if
// Stream channels of the box filter: input items and result items.
// ----------------------------------------------------------------------------
interface sbf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [sbf_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface sbf_out_if;
  logic                      valid;
  logic                      ready;
  logic [sbf_pkg::PIX_W-1:0] pixel_out;
  logic                      frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// File: sv/separable_box_filter_8bit_unit.sv
// ----------------------------------------------------------------------------
// separable_box_filter_8bit_unit
// Streaming separable box filter over a ring of line stores.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    opcode, pixel_in
//  out_ch    out  valid/ready    pixel_out, frame_last
//  cfg       in   cfg_wr_en      cfg_index, cfg_data
//
//  An item that gives no result leaves the sequencer in ST_IDLE. An item that
//  gives a result walks L averaged lines (L = kh or 1): per line one line store
//  read per window pixel and one serial divide, then one divide for the column.
//  The divider is NW bits wide (13 at defaults).
//  rst is synchronous; the line store is not cleared. A full output register
//  holds the next result in its last step until out_ch takes the beat.
// ----------------------------------------------------------------------------
module separable_box_filter_8bit_unit #(
  parameter int MAX_WIDTH         = sbf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL_WIDTH  = sbf_pkg::MAX_KERNEL_WIDTH_DEF,
  parameter int MAX_KERNEL_HEIGHT = sbf_pkg::MAX_KERNEL_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sbf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  sbf_in_if.sink                          in_ch,
  sbf_out_if.source                       out_ch
);

  import sbf_pkg::*;

  localparam int KMAX  = (MAX_KERNEL_WIDTH > MAX_KERNEL_HEIGHT) ?
                         MAX_KERNEL_WIDTH : MAX_KERNEL_HEIGHT;
  localparam int SW    = $clog2(KMAX * 255 + 1);
  localparam int KWW   = $clog2(MAX_KERNEL_WIDTH + 1);
  localparam int KHW   = $clog2(MAX_KERNEL_HEIGHT + 1);
  localparam int DW    = (KWW > KHW) ? KWW : KHW;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LW    = $clog2(MAX_KERNEL_HEIGHT);
  localparam int DEPTH = MAX_KERNEL_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ((WW > KWW) ? WW : KWW) + 1;
  localparam int YW    = IMG_H_W + 1;
  localparam int FW    = WW + IMG_H_W;
  localparam int PW    = $clog2(MAX_KERNEL_WIDTH + MAX_KERNEL_HEIGHT * MAX_WIDTH + 2);
  localparam int TW    = ((FW > PW) ? FW : PW) + 1;

  // configuration
  logic [IMG_W_W-1:0] reg_w;
  logic [IMG_H_W-1:0] reg_h;
  logic [KER_W-1:0]   reg_kw;
  logic [KER_W-1:0]   reg_kh;

  logic [WW-1:0]      gw;
  logic [IMG_H_W-1:0] gh;
  logic [KWW-1:0]     gkw, hhalf, dh;
  logic [KHW-1:0]     gkh, vhalf, dv;
  logic               h_fit, v_fit;
  logic [PW-1:0]      lag;
  logic [FW-1:0]      total;

  // positions
  logic [CW-1:0]      in_column, out_column;
  logic [IMG_H_W-1:0] in_row, out_row;
  logic [LW-1:0]      in_line, out_line;
  logic [PW-1:0]      pending;
  logic [FW-1:0]      out_pos;

  // sequencer
  state_t             state, state_next;
  logic               in_fire, give, hor, vert, last_pix;
  logic [LW:0]        start_sum;
  logic [LW-1:0]      start_line, line_ptr;
  logic [CW-1:0]      col_ptr;
  logic [KWW-1:0]     hcnt;
  logic [KHW-1:0]     lines_left;
  logic [SW-1:0]      hacc, vacc;
  logic               rd_pend;
  logic               mem_re, div_start, out_load;
  logic [SW-1:0]      div_num;
  logic [DW-1:0]      div_den;
  logic               div_done;
  logic [SW-1:0]      div_quo;
  logic [PIX_W-1:0]   result;
  logic               out_valid;
  logic [PIX_W-1:0]   pixel_out;
  logic               frame_last;

  // line store
  logic [PIX_W-1:0]   mem [DEPTH];
  logic [PIX_W-1:0]   rdata;
  logic [AW-1:0]      waddr, raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w  <= IMAGE_WIDTH_RST;
      reg_h  <= IMAGE_HEIGHT_RST;
      reg_kw <= KERNEL_WIDTH_RST;
      reg_kh <= KERNEL_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   reg_w  <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:  reg_h  <= cfg_data[IMG_H_W-1:0];
        CFG_KERNEL_WIDTH:  reg_kw <= cfg_data[KER_W-1:0];
        CFG_KERNEL_HEIGHT: reg_kh <= cfg_data[KER_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to the supported range
  always_comb begin
    if (reg_w == '0)                 gw = WW'(1);
    else if (32'(reg_w) > MAX_WIDTH) gw = WW'(MAX_WIDTH);
    else                             gw = WW'(reg_w);
    gh = (reg_h == '0) ? IMG_H_W'(1) : reg_h;
    if (reg_kw == '0)                       gkw = KWW'(1);
    else if (32'(reg_kw) > MAX_KERNEL_WIDTH) gkw = KWW'(MAX_KERNEL_WIDTH);
    else                                    gkw = KWW'(reg_kw);
    if (reg_kh == '0)                        gkh = KHW'(1);
    else if (32'(reg_kh) > MAX_KERNEL_HEIGHT) gkh = KHW'(MAX_KERNEL_HEIGHT);
    else                                     gkh = KHW'(reg_kh);
  end

  assign hhalf = gkw >> 1;
  assign vhalf = gkh >> 1;
  assign h_fit = XW'(gkw) <= XW'(gw);
  assign v_fit = YW'(gkh) <= YW'(gh);
  assign dh    = h_fit ? KWW'(gkw - 1'b1 - hhalf) : '0;
  assign dv    = v_fit ? KHW'(gkh - 1'b1 - vhalf) : '0;
  assign lag   = PW'(dh) + PW'(PW'(dv) * PW'(gw));
  assign total = FW'(gw) * FW'(gh);

  // window fit for the next result
  assign hor = h_fit && (XW'(out_column) >= XW'(hhalf)) &&
               (XW'(out_column) + XW'(gkw) <= XW'(gw) + XW'(hhalf));
  assign vert = v_fit && (YW'(out_row) >= YW'(vhalf)) &&
                (YW'(out_row) + YW'(gkh) <= YW'(gh) + YW'(vhalf));

  assign start_sum  = (LW+1)'(out_line) + (LW+1)'(MAX_KERNEL_HEIGHT) - (LW+1)'(vhalf);
  assign start_line = (start_sum >= (LW+1)'(MAX_KERNEL_HEIGHT)) ?
                      LW'(start_sum - (LW+1)'(MAX_KERNEL_HEIGHT)) :
                      LW'(start_sum);

  assign last_pix = (out_row == gh - 1'b1) && (WW'(out_column) == gw - 1'b1);

  assign in_fire = in_ch.valid && in_ch.ready;
  always_comb begin
    if (in_ch.opcode == OP_PIXEL)
      give = (pending + 1'b1) > lag;
    else
      give = (pending != '0) && (TW'(out_pos) + TW'(pending) >= TW'(total));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire && give) state_next = ST_LINE;
      ST_LINE:   state_next = ST_READ;
      ST_READ:   if (hcnt == KWW'(1)) state_next = ST_LAST;
      ST_LAST:   state_next = ST_HDIV;
      ST_HDIV:   state_next = ST_HWAIT;
      ST_HWAIT:  if (div_done) state_next = (lines_left == KHW'(1)) ? ST_VDIV : ST_LINE;
      ST_VDIV:   state_next = ST_VWAIT;
      ST_VWAIT:  if (div_done) state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    div_num     = hacc;
    div_den     = hor ? DW'(gkw) : DW'(1);
    unique case (state)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_READ:   mem_re = 1'b1;
      ST_HDIV:   div_start = 1'b1;
      ST_VDIV: begin
        div_start = 1'b1;
        div_num   = vacc;
        div_den   = vert ? DW'(gkh) : DW'(1);
      end
      ST_RESULT: out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // positions and pending count
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      in_column  <= '0;
      in_row     <= '0;
      in_line    <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_line   <= '0;
      out_pos    <= '0;
      pending    <= '0;
    end else begin
      if (in_fire && in_ch.opcode == OP_PIXEL) begin
        pending <= pending + 1'b1;
        if (WW'(in_column) + 1'b1 >= gw) begin
          in_column <= '0;
          in_line   <= (in_line == LW'(MAX_KERNEL_HEIGHT - 1)) ? '0 : in_line + 1'b1;
          in_row    <= (in_row + 1'b1 >= gh) ? '0 : in_row + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
      end
      if (out_load) begin
        pending <= pending - 1'b1;
        out_pos <= last_pix ? '0 : out_pos + 1'b1;
        if (WW'(out_column) + 1'b1 >= gw) begin
          out_column <= '0;
          out_line   <= (out_line == LW'(MAX_KERNEL_HEIGHT - 1)) ? '0 : out_line + 1'b1;
          out_row    <= (out_row + 1'b1 >= gh) ? '0 : out_row + 1'b1;
        end else begin
          out_column <= out_column + 1'b1;
        end
      end
    end
  end

  // window walk and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      line_ptr   <= vert ? start_line : out_line;
      lines_left <= vert ? gkh : KHW'(1);
      vacc       <= '0;
    end
    if (state == ST_LINE) begin
      col_ptr <= hor ? out_column - CW'(hhalf) : out_column;
      hcnt    <= hor ? gkw : KWW'(1);
      hacc    <= '0;
    end
    if (mem_re) begin
      col_ptr <= col_ptr + 1'b1;
      hcnt    <= hcnt - 1'b1;
    end
    if (rd_pend) hacc <= hacc + SW'(rdata);
    if (state == ST_HWAIT && div_done) begin
      vacc       <= vacc + SW'(div_quo[PIX_W-1:0]);
      lines_left <= lines_left - 1'b1;
      line_ptr   <= (line_ptr == LW'(MAX_KERNEL_HEIGHT - 1)) ? '0 : line_ptr + 1'b1;
    end
    if (state == ST_VWAIT && div_done) result <= div_quo[PIX_W-1:0];
  end

  assign waddr = AW'(AW'(in_line) * AW'(MAX_WIDTH)) + AW'(in_column);
  assign raddr = AW'(AW'(line_ptr) * AW'(MAX_WIDTH)) + AW'(col_ptr);

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.opcode == OP_PIXEL) mem[waddr] <= in_ch.pixel_in;
    if (mem_re) rdata <= mem[raddr];
  end

  sbf_div #(
    .NW (SW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out  <= result;
      frame_last <= last_pix;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.pixel_out  = pixel_out;
  assign out_ch.frame_last = frame_last;

endmodule

// File: sv/sbf_div.sv
// ----------------------------------------------------------------------------
// sbf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbf_div #(
  parameter int NW = 13,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;

  assign trial    = {rem, num[NW-1]};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= DW'(trial - {1'b0, dsr});
        num <= {num[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        num <= {num[NW-2:0], 1'b0};
      end
    end
  end

endmodule
